@@ design/b32d_pkg.sv @@
// Shared types, constants and status codes for the base32 code decoder.
package b32d_pkg;

  // Symbols in one complete code, and the bytes that they carry.
  localparam int unsigned CODE_SYMBOLS = 16;
  localparam int unsigned SYM_BITS     = 5;
  localparam int unsigned CODE_BYTES   = (CODE_SYMBOLS * SYM_BITS) / 8;
  localparam int unsigned SYM_CNT_W    = $clog2(CODE_SYMBOLS + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_TOO_FEW  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } in_word_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] byte_value;
    logic [3:0] byte_index;
    status_e    status;
  } out_word_t;

  typedef struct packed {
    logic                is_skip;
    logic                is_symbol;
    logic [SYM_BITS-1:0] value;
  } sym_info_t;

endpackage

@@ design/b32d_symbol_map.sv @@
// Character classifier: folds case, applies aliases and maps to a 5-bit symbol.
module b32d_symbol_map (
  input  logic [7:0]          ch_i,
  output b32d_pkg::sym_info_t info_o
);
  import b32d_pkg::*;

  logic [7:0] up;

  always_comb begin
    up = ch_i;
    if (ch_i inside {[8'h61:8'h7A]}) begin
      up = ch_i - 8'd32;
    end
  end

  always_comb begin
    info_o.is_skip   = (ch_i == 8'h2D) || (ch_i == 8'h20);
    info_o.is_symbol = 1'b1;
    info_o.value     = '0;
    if (up inside {[8'h30:8'h39]}) begin
      info_o.value = SYM_BITS'(up - 8'h30);
    end else if (up inside {[8'h41:8'h48]}) begin       // A..H
      info_o.value = SYM_BITS'(up - 8'h41 + 8'd10);
    end else if (up inside {8'h4A, 8'h4B}) begin        // J, K
      info_o.value = SYM_BITS'(up - 8'h4A + 8'd18);
    end else if (up inside {8'h4D, 8'h4E}) begin        // M, N
      info_o.value = SYM_BITS'(up - 8'h4D + 8'd20);
    end else if (up inside {[8'h50:8'h54]}) begin       // P..T
      info_o.value = SYM_BITS'(up - 8'h50 + 8'd22);
    end else if (up inside {[8'h56:8'h5A]}) begin       // V..Z
      info_o.value = SYM_BITS'(up - 8'h56 + 8'd27);
    end else if (up == 8'h4F) begin                     // O reads as zero
      info_o.value = '0;
    end else if (up inside {8'h49, 8'h4C}) begin        // I, L read as one
      info_o.value = SYM_BITS'(1);
    end else begin
      info_o.is_symbol = 1'b0;
    end
  end

endmodule

@@ design/base32_code_decoder.sv @@
// Top level of the base32 code decoder: input register, decode step, result register.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------------
//  in      | sink      | in_valid_i / in_ready_o  | in_word_i  (ch, is_end)
//  out     | source    | out_valid_o / out_ready_i| out_word_o (is_status, byte,
//          |           |                          |             index, status)
//
// One word a cycle is taken in steady flow, while the output does not stall.
// A word is captured in the input register and decoded there; its result, if
// any, is then written into the result register.
// The decode step runs when the result register is empty or being drained, so
// a stall on the output holds both registers and, once the input register
// holds a word, lowers in_ready_o.
// Reset clears the decode state, as does every end word.
module base32_code_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  b32d_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b32d_pkg::out_word_t out_word_o
);
  import b32d_pkg::*;

  // Input register
  logic     in_valid_q;
  in_word_t in_word_q;

  // Decode state
  logic [6:0]           bit_buf_q,  bit_buf_d;
  logic [2:0]           bit_cnt_q,  bit_cnt_d;
  logic [SYM_CNT_W-1:0] sym_cnt_q,  sym_cnt_d;
  logic [3:0]           byte_cnt_q, byte_cnt_d;
  logic                 failed_q,   failed_d;

  // Result register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q,  out_word_d;

  logic      advance;
  logic      step;
  sym_info_t info;

  logic [11:0] acc;
  logic [3:0]  nbits;
  logic [2:0]  rest;

  // Advance when the result slot is free or being taken this cycle.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  b32d_symbol_map u_map (
    .ch_i   (in_word_q.ch),
    .info_o (info)
  );

  assign acc   = {bit_buf_q, info.value};
  assign nbits = {1'b0, bit_cnt_q} + 4'd5;
  assign rest  = 3'(nbits - 4'd8);

  always_comb begin
    bit_buf_d   = bit_buf_q;
    bit_cnt_d   = bit_cnt_q;
    sym_cnt_d   = sym_cnt_q;
    byte_cnt_d  = byte_cnt_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;

    if (step) begin
      out_valid_d = 1'b0;
      out_word_d  = '0;
      if (in_word_q.is_end) begin
        // Report the outcome unless an error was already reported; clear all.
        if (!failed_q) begin
          out_valid_d          = 1'b1;
          out_word_d.is_status = 1'b1;
          out_word_d.status    = (sym_cnt_q == SYM_CNT_W'(CODE_SYMBOLS)) ?
                                 ST_OK : ST_TOO_FEW;
        end
        bit_buf_d  = '0;
        bit_cnt_d  = '0;
        sym_cnt_d  = '0;
        byte_cnt_d = '0;
        failed_d   = 1'b0;
      end else if (failed_q || info.is_skip) begin
        // Drop the word.
      end else if (!info.is_symbol) begin
        failed_d             = 1'b1;
        out_valid_d          = 1'b1;
        out_word_d.is_status = 1'b1;
        out_word_d.status    = ST_BAD_CHAR;
      end else if (sym_cnt_q >= SYM_CNT_W'(CODE_SYMBOLS)) begin
        failed_d             = 1'b1;
        out_valid_d          = 1'b1;
        out_word_d.is_status = 1'b1;
        out_word_d.status    = ST_TOO_MANY;
      end else begin
        sym_cnt_d = sym_cnt_q + SYM_CNT_W'(1);
        if (nbits >= 4'd8) begin
          // Emit the top eight bits, keep the rest.
          out_valid_d           = 1'b1;
          out_word_d.byte_value = 8'(acc >> rest);
          out_word_d.byte_index = byte_cnt_q;
          byte_cnt_d            = byte_cnt_q + 4'd1;
          bit_buf_d             = 7'(acc & ((12'd1 << rest) - 12'd1));
          bit_cnt_d             = rest;
        end else begin
          bit_buf_d = acc[6:0];
          bit_cnt_d = nbits[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bit_buf_q   <= '0;
      bit_cnt_q   <= '0;
      sym_cnt_q   <= '0;
      byte_cnt_q  <= '0;
      failed_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      bit_buf_q   <= bit_buf_d;
      bit_cnt_q   <= bit_cnt_d;
      sym_cnt_q   <= sym_cnt_d;
      byte_cnt_q  <= byte_cnt_d;
      failed_q    <= failed_d;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ design/b32d_checker.sv @@
// Port-level checker for the base32 code decoder, bound to the top level.
module b32d_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input b32d_pkg::out_word_t out_word_o
);
  import b32d_pkg::*;

  // Hold a stalled result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed under stall");

  // Status words carry no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.is_status |->
      out_word_o.byte_value == 8'd0 && out_word_o.byte_index == 4'd0)
    else $error("status word carries byte fields");

  // Byte words stay within the code length and carry status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.is_status |->
      out_word_o.byte_index < 4'(CODE_BYTES) && out_word_o.status == ST_OK)
    else $error("byte word out of range");

endmodule

bind base32_code_decoder b32d_checker u_b32d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
